[hdl/cct_pkg.sv]
// Shared types and constants for the cook countdown timer.
package cct_pkg;

  localparam int unsigned TimeW = 27;
  localparam int unsigned OpW   = 3;
  localparam int unsigned CntW  = 5;
  localparam int unsigned OutW  = 2 * TimeW + 3;

  // One day in milliseconds; every stored time saturates here.
  localparam logic [TimeW-1:0] DAY_MS = TimeW'(24 * 60 * 60 * 1000);

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_RUN   = 3'd1,
    OP_STOP  = 3'd2,
    OP_PAUSE = 3'd3,
    OP_CLEAR = 3'd4,
    OP_SET   = 3'd5,
    OP_STEP  = 3'd6
  } op_e;

  typedef struct packed {
    logic apply;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  typedef struct packed {
    logic             has_run;
    logic             finished;
    logic             running;
    logic [TimeW-1:0] target_ms;
    logic [TimeW-1:0] remaining_ms;
  } result_t;

endpackage

[hdl/cct_datapath.sv]
// Timer state, remainder divider for the step operation, and result register.
module cct_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cct_pkg::cmd_t                   cmd_i,
  output cct_pkg::status_t                status_o,
  input  logic [cct_pkg::OpW-1:0]         op_i,
  input  logic [cct_pkg::TimeW-1:0]       amount_i,
  input  logic                            step_down_i,
  input  logic [cct_pkg::TimeW-1:0]       step_ms_i,
  output cct_pkg::result_t                result_o
);

  localparam int unsigned W = cct_pkg::TimeW;

  logic [W-1:0] target_q, target_d;
  logic [W-1:0] elapsed_q, elapsed_d;
  logic         run_q, run_d;
  logic         ran_q, ran_d;

  logic [W-1:0]              step_q;
  logic                      down_q;
  logic [W-1:0]              dividend_q, dividend_d;
  logic [W-1:0]              rem_q, rem_d;
  logic [W:0]                base_q, base_d;
  logic [cct_pkg::CntW-1:0]  cnt_q, cnt_d;

  cct_pkg::result_t result_q, result_d;

  logic [W:0]   tick_sum;
  logic [W:0]   rem_shift;
  logic [W:0]   step_res;
  logic [W-1:0] step_target;

  always_comb begin
    tick_sum  = {1'b0, elapsed_q} + {1'b0, amount_i};
    rem_shift = {rem_q, dividend_q[W-1]};
    step_res  = base_q - {1'b0, rem_q};

    if (step_q == '0) begin
      step_target = target_q;
    end else if (down_q) begin
      step_target = (target_q > step_q) ? step_res[W-1:0] : '0;
    end else begin
      step_target = (step_res > {1'b0, cct_pkg::DAY_MS}) ? cct_pkg::DAY_MS : step_res[W-1:0];
    end
  end

  always_comb begin
    target_d   = target_q;
    elapsed_d  = elapsed_q;
    run_d      = run_q;
    ran_d      = ran_q;
    dividend_d = dividend_q;
    rem_d      = rem_q;
    base_d     = base_q;
    cnt_d      = cnt_q;

    if (cmd_i.apply) begin
      case (cct_pkg::op_e'(op_i))
        cct_pkg::OP_TICK: begin
          if (run_q) begin
            elapsed_d = (tick_sum > {1'b0, cct_pkg::DAY_MS}) ? cct_pkg::DAY_MS
                                                             : tick_sum[W-1:0];
          end
        end
        cct_pkg::OP_RUN: begin
          if (!run_q) begin
            run_d = 1'b1;
            ran_d = 1'b1;
          end
        end
        cct_pkg::OP_STOP: begin
          run_d = 1'b0;
        end
        cct_pkg::OP_PAUSE: begin
          ran_d     = 1'b0;
          run_d     = 1'b0;
          target_d  = (target_q > elapsed_q) ? target_q - elapsed_q : '0;
          elapsed_d = '0;
        end
        cct_pkg::OP_CLEAR: begin
          ran_d = 1'b0;
        end
        cct_pkg::OP_SET: begin
          target_d = (amount_i > cct_pkg::DAY_MS) ? cct_pkg::DAY_MS : amount_i;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.div_start) begin
      // Rounding down works on target - 1, rounding up on target itself.
      dividend_d = step_down_i ? target_q - W'(1) : target_q;
      base_d     = step_down_i ? {1'b0, target_q - W'(1)}
                               : {1'b0, target_q} + {1'b0, step_ms_i};
      rem_d      = '0;
      cnt_d      = cct_pkg::CntW'(W - 1);
    end

    if (cmd_i.div_step) begin
      dividend_d = {dividend_q[W-2:0], 1'b0};
      if (rem_shift >= {1'b0, step_q}) begin
        rem_d = W'(rem_shift - {1'b0, step_q});
      end else begin
        rem_d = rem_shift[W-1:0];
      end
      cnt_d = cnt_q - cct_pkg::CntW'(1);
    end

    if (cmd_i.div_finish) begin
      target_d = step_target;
    end
  end

  always_comb begin
    result_d              = result_q;
    result_d.remaining_ms = (elapsed_q >= target_q) ? '0 : target_q - elapsed_q;
    result_d.target_ms    = target_q;
    result_d.running      = run_q;
    result_d.finished     = (elapsed_q >= target_q) && ran_q;
    result_d.has_run      = ran_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      elapsed_q <= '0;
      run_q     <= 1'b0;
      ran_q     <= 1'b0;
    end else begin
      target_q  <= target_d;
      elapsed_q <= elapsed_d;
      run_q     <= run_d;
      ran_q     <= ran_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    rem_q      <= rem_d;
    base_q     <= base_d;
    cnt_q      <= cnt_d;
    if (cmd_i.div_start) begin
      step_q <= step_ms_i;
      down_q <= step_down_i;
    end
    if (cmd_i.out_load) begin
      result_q <= result_d;
    end
  end

  assign status_o.div_last = (cnt_q == '0);
  assign result_o          = result_q;

endmodule

[hdl/cct_controller.sv]
// Sequencing state machine and handshake control for the cook countdown timer.
module cct_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [cct_pkg::OpW-1:0]  op_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  cct_pkg::status_t         status_i,
  output cct_pkg::cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_FIN    = 4'b0100,
    ST_REPORT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cct_pkg::op_e'(op_i) == cct_pkg::OP_STEP) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            cmd_o.apply = 1'b1;
            state_d     = ST_REPORT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/cook_countdown_timer.sv]
// Top level of the cook countdown timer.
// Each request passes through the result register; a step first runs the bit-serial
// remainder divider. A new request is taken only once the result register is loaded,
// which waits while an earlier result is still unacknowledged downstream.
// Reset clears target, elapsed time, run and has-run flags and the result valid.
module cook_countdown_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // amount_ms[26:0], step_down[27], step_ms[54:28]
  input  logic [7:0]  s_axis_tuser,   // op[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // remaining_ms[26:0], target_ms[53:27], running[54],
                                      // finished[55], has_run[56]
);

  localparam int unsigned W = cct_pkg::TimeW;

  cct_pkg::cmd_t    cmd;
  cct_pkg::status_t status;
  cct_pkg::result_t result;

  cct_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser[cct_pkg::OpW-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cct_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (s_axis_tuser[cct_pkg::OpW-1:0]),
    .amount_i    (s_axis_tdata[W-1:0]),
    .step_down_i (s_axis_tdata[W]),
    .step_ms_i   (s_axis_tdata[2*W:W+1]),
    .result_o    (result)
  );

  assign m_axis_tdata = {(64 - cct_pkg::OutW)'(0), result};

  a_no_accept_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !s_axis_tready)
    else $error("request accepted while the divider is busy");

  a_target_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result.target_ms <= cct_pkg::DAY_MS))
    else $error("target exceeds one day");

  a_finished_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.finished) |-> (result.remaining_ms == '0))
    else $error("finished with time remaining");

  a_finished_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.finished) |-> result.has_run)
    else $error("finished without the has-run flag");

endmodule
